// ===== rtl/core/mrth_pkg.sv =====
package mrth_pkg;

    localparam int DEFAULT_MAX_TRIANGLES = 16;

    localparam int COORD_W   = 32;
    localparam int DIFF_W    = 33;
    localparam int OP_W      = 34;
    localparam int PROD_W    = 68;
    localparam int CROSS_W   = 67;
    localparam int ACC_W     = 104;
    localparam int REM_W     = ACC_W + 1;
    localparam int HI_SHIFT  = 33;
    localparam int Q_W       = 31;
    localparam int FRAC_BITS = 30;

    localparam int TC_W       = 5;
    localparam int DET_THR_W  = 40;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 40;
    localparam int SLOT_W     = 4;
    localparam int CORNER_W   = 2;
    localparam int TRI_OUT_W  = 4;

    localparam int STEP_W    = 6;
    localparam int MAC_STEPS = 36;
    localparam int LOAD_LAST = 3;
    localparam int DIV_STEPS = 30;

    localparam logic [TC_W-1:0]      TC_RESET      = 5'd0;
    localparam logic [DET_THR_W-1:0] DET_THR_RESET = 40'd281474977;
    localparam logic [Q_W-1:0]       T_THR_RESET   = 31'd1074;
    localparam logic [Q_W-1:0]       Q_ONE         = 31'h4000_0000;

    localparam logic [CFG_IDX_W-1:0] REG_TRI_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DET_THR   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_T_THR     = 2'd2;

    localparam logic KIND_CORNER = 1'b0;
    localparam logic KIND_QUERY  = 1'b1;

    localparam logic [CORNER_W-1:0] NUM_CORNERS = 2'd3;

    localparam logic [2:0] A_DIR   = 3'd0;
    localparam logic [2:0] A_SV    = 3'd1;
    localparam logic [2:0] A_PV_LO = 3'd2;
    localparam logic [2:0] A_PV_HI = 3'd3;
    localparam logic [2:0] A_QV_LO = 3'd4;
    localparam logic [2:0] A_QV_HI = 3'd5;

    localparam logic [1:0] B_E1  = 2'd0;
    localparam logic [1:0] B_E2  = 2'd1;
    localparam logic [1:0] B_SV  = 2'd2;
    localparam logic [1:0] B_DIR = 2'd3;

    localparam logic [3:0] D_PV0 = 4'd0;
    localparam logic [3:0] D_PV1 = 4'd1;
    localparam logic [3:0] D_PV2 = 4'd2;
    localparam logic [3:0] D_QV0 = 4'd3;
    localparam logic [3:0] D_QV1 = 4'd4;
    localparam logic [3:0] D_QV2 = 4'd5;
    localparam logic [3:0] D_DET = 4'd6;
    localparam logic [3:0] D_NU  = 4'd7;
    localparam logic [3:0] D_NV  = 4'd8;
    localparam logic [3:0] D_NT  = 4'd9;

    localparam logic [1:0] SEL_T = 2'd0;
    localparam logic [1:0] SEL_U = 2'd1;
    localparam logic [1:0] SEL_V = 2'd2;

    typedef struct packed {
        logic       en;
        logic [2:0] a_src;
        logic [1:0] a_idx;
        logic [1:0] b_src;
        logic [1:0] b_idx;
        logic       neg;
        logic       first;
        logic       last;
        logic [3:0] dest;
    } mac_cmd_t;

    typedef struct packed {
        logic                 ram_we;
        logic                 ram_re;
        logic                 load_query;
        logic                 ld_c0;
        logic                 ld_c1;
        logic                 ld_c2;
        mac_cmd_t             mac;
        logic                 chk;
        logic                 div_init;
        logic                 div_step;
        logic [1:0]           div_sel;
        logic                 div_save;
        logic                 out_load;
        logic                 out_hit;
        logic [TRI_OUT_W-1:0] out_tri;
    } dp_cmd_t;

    typedef struct packed {
        logic det_bad;
        logic range_bad;
        logic t_low;
    } dp_stat_t;

    function automatic mac_cmd_t mk(input logic [2:0] a_src, input logic [1:0] a_idx,
                                    input logic [1:0] b_src, input logic [1:0] b_idx,
                                    input logic neg, input logic first, input logic last,
                                    input logic [3:0] dest);
        mac_cmd_t c;
        c.en    = 1'b1;
        c.a_src = a_src;
        c.a_idx = a_idx;
        c.b_src = b_src;
        c.b_idx = b_idx;
        c.neg   = neg;
        c.first = first;
        c.last  = last;
        c.dest  = dest;
        return c;
    endfunction

    // Products of one triangle test: two cross products, then four dot products
    // whose wide operand is split into a low and a high part.
    function automatic mac_cmd_t mac_step(input logic [STEP_W-1:0] s);
        mac_cmd_t c;
        c = '0;
        unique case (s)
            6'd0:  c = mk(A_DIR, 2'd1, B_E2, 2'd2, 1'b0, 1'b1, 1'b0, D_PV0);
            6'd1:  c = mk(A_DIR, 2'd2, B_E2, 2'd1, 1'b1, 1'b0, 1'b1, D_PV0);
            6'd2:  c = mk(A_DIR, 2'd2, B_E2, 2'd0, 1'b0, 1'b1, 1'b0, D_PV1);
            6'd3:  c = mk(A_DIR, 2'd0, B_E2, 2'd2, 1'b1, 1'b0, 1'b1, D_PV1);
            6'd4:  c = mk(A_DIR, 2'd0, B_E2, 2'd1, 1'b0, 1'b1, 1'b0, D_PV2);
            6'd5:  c = mk(A_DIR, 2'd1, B_E2, 2'd0, 1'b1, 1'b0, 1'b1, D_PV2);
            6'd6:  c = mk(A_SV, 2'd1, B_E1, 2'd2, 1'b0, 1'b1, 1'b0, D_QV0);
            6'd7:  c = mk(A_SV, 2'd2, B_E1, 2'd1, 1'b1, 1'b0, 1'b1, D_QV0);
            6'd8:  c = mk(A_SV, 2'd2, B_E1, 2'd0, 1'b0, 1'b1, 1'b0, D_QV1);
            6'd9:  c = mk(A_SV, 2'd0, B_E1, 2'd2, 1'b1, 1'b0, 1'b1, D_QV1);
            6'd10: c = mk(A_SV, 2'd0, B_E1, 2'd1, 1'b0, 1'b1, 1'b0, D_QV2);
            6'd11: c = mk(A_SV, 2'd1, B_E1, 2'd0, 1'b1, 1'b0, 1'b1, D_QV2);
            6'd12: c = mk(A_PV_LO, 2'd0, B_E1, 2'd0, 1'b0, 1'b1, 1'b0, D_DET);
            6'd13: c = mk(A_PV_HI, 2'd0, B_E1, 2'd0, 1'b0, 1'b0, 1'b0, D_DET);
            6'd14: c = mk(A_PV_LO, 2'd1, B_E1, 2'd1, 1'b0, 1'b0, 1'b0, D_DET);
            6'd15: c = mk(A_PV_HI, 2'd1, B_E1, 2'd1, 1'b0, 1'b0, 1'b0, D_DET);
            6'd16: c = mk(A_PV_LO, 2'd2, B_E1, 2'd2, 1'b0, 1'b0, 1'b0, D_DET);
            6'd17: c = mk(A_PV_HI, 2'd2, B_E1, 2'd2, 1'b0, 1'b0, 1'b1, D_DET);
            6'd18: c = mk(A_PV_LO, 2'd0, B_SV, 2'd0, 1'b0, 1'b1, 1'b0, D_NU);
            6'd19: c = mk(A_PV_HI, 2'd0, B_SV, 2'd0, 1'b0, 1'b0, 1'b0, D_NU);
            6'd20: c = mk(A_PV_LO, 2'd1, B_SV, 2'd1, 1'b0, 1'b0, 1'b0, D_NU);
            6'd21: c = mk(A_PV_HI, 2'd1, B_SV, 2'd1, 1'b0, 1'b0, 1'b0, D_NU);
            6'd22: c = mk(A_PV_LO, 2'd2, B_SV, 2'd2, 1'b0, 1'b0, 1'b0, D_NU);
            6'd23: c = mk(A_PV_HI, 2'd2, B_SV, 2'd2, 1'b0, 1'b0, 1'b1, D_NU);
            6'd24: c = mk(A_QV_LO, 2'd0, B_DIR, 2'd0, 1'b0, 1'b1, 1'b0, D_NV);
            6'd25: c = mk(A_QV_HI, 2'd0, B_DIR, 2'd0, 1'b0, 1'b0, 1'b0, D_NV);
            6'd26: c = mk(A_QV_LO, 2'd1, B_DIR, 2'd1, 1'b0, 1'b0, 1'b0, D_NV);
            6'd27: c = mk(A_QV_HI, 2'd1, B_DIR, 2'd1, 1'b0, 1'b0, 1'b0, D_NV);
            6'd28: c = mk(A_QV_LO, 2'd2, B_DIR, 2'd2, 1'b0, 1'b0, 1'b0, D_NV);
            6'd29: c = mk(A_QV_HI, 2'd2, B_DIR, 2'd2, 1'b0, 1'b0, 1'b1, D_NV);
            6'd30: c = mk(A_QV_LO, 2'd0, B_E2, 2'd0, 1'b0, 1'b1, 1'b0, D_NT);
            6'd31: c = mk(A_QV_HI, 2'd0, B_E2, 2'd0, 1'b0, 1'b0, 1'b0, D_NT);
            6'd32: c = mk(A_QV_LO, 2'd1, B_E2, 2'd1, 1'b0, 1'b0, 1'b0, D_NT);
            6'd33: c = mk(A_QV_HI, 2'd1, B_E2, 2'd1, 1'b0, 1'b0, 1'b0, D_NT);
            6'd34: c = mk(A_QV_LO, 2'd2, B_E2, 2'd2, 1'b0, 1'b0, 1'b0, D_NT);
            6'd35: c = mk(A_QV_HI, 2'd2, B_E2, 2'd2, 1'b0, 1'b0, 1'b1, D_NT);
            default: c = '0;
        endcase
        return c;
    endfunction

endpackage

// ===== rtl/core/mesh_ray_triangle_hit.sv =====
// A corner write is taken while idle. A query walks the triangles in index order; each
// triangle has its corners read, its products formed on the shared 34x34 multiplier,
// its checks made and an advance; a passing one divides for t and, on a hit, for u and
// v, one quotient bit per cycle in the restoring divider. The result is registered.
// Reset clears the controller, the output valid and the configuration registers to
// their defaults; the corner store has no reset and holds garbage until written.
module mesh_ray_triangle_hit #(
    parameter int MAX_TRIANGLES = mrth_pkg::DEFAULT_MAX_TRIANGLES
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                kind,
    input  logic [mrth_pkg::SLOT_W-1:0]         tri_slot,
    input  logic [mrth_pkg::CORNER_W-1:0]       corner,
    input  logic signed [mrth_pkg::COORD_W-1:0] pos_x,
    input  logic signed [mrth_pkg::COORD_W-1:0] pos_y,
    input  logic signed [mrth_pkg::COORD_W-1:0] pos_z,
    input  logic signed [mrth_pkg::COORD_W-1:0] step_x,
    input  logic signed [mrth_pkg::COORD_W-1:0] step_y,
    input  logic signed [mrth_pkg::COORD_W-1:0] step_z,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic                                hit,
    output logic [mrth_pkg::TRI_OUT_W-1:0]      hit_triangle,
    output logic [mrth_pkg::Q_W-1:0]            hit_t,
    output logic [mrth_pkg::Q_W-1:0]            hit_u,
    output logic [mrth_pkg::Q_W-1:0]            hit_v,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [mrth_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [mrth_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int AW = $clog2(3 * MAX_TRIANGLES);

    logic [mrth_pkg::TC_W-1:0]      tc_reg;
    logic [mrth_pkg::DET_THR_W-1:0] det_thr_reg;
    logic [mrth_pkg::Q_W-1:0]       t_thr_reg;
    mrth_pkg::dp_cmd_t              cmd;
    mrth_pkg::dp_stat_t             stat;
    logic [AW-1:0]                  raddr;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tc_reg      <= mrth_pkg::TC_RESET;
            det_thr_reg <= mrth_pkg::DET_THR_RESET;
            t_thr_reg   <= mrth_pkg::T_THR_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                mrth_pkg::REG_TRI_COUNT: tc_reg      <= cfg_data[mrth_pkg::TC_W-1:0];
                mrth_pkg::REG_DET_THR:   det_thr_reg <= cfg_data[mrth_pkg::DET_THR_W-1:0];
                mrth_pkg::REG_T_THR:     t_thr_reg   <= cfg_data[mrth_pkg::Q_W-1:0];
                default: ;
            endcase
        end
    end

    mrth_ctrl #(
        .MAX_TRIANGLES(MAX_TRIANGLES)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .kind     (kind),
        .tri_slot (tri_slot),
        .corner   (corner),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .tri_count(tc_reg),
        .stat     (stat),
        .cmd      (cmd),
        .raddr    (raddr)
    );

    mrth_datapath #(
        .MAX_TRIANGLES(MAX_TRIANGLES)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .raddr       (raddr),
        .tri_slot    (tri_slot),
        .corner      (corner),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .pos_z       (pos_z),
        .step_x      (step_x),
        .step_y      (step_y),
        .step_z      (step_z),
        .det_thr     (det_thr_reg),
        .t_thr       (t_thr_reg),
        .stat        (stat),
        .hit         (hit),
        .hit_triangle(hit_triangle),
        .hit_t       (hit_t),
        .hit_u       (hit_u),
        .hit_v       (hit_v)
    );

endmodule

// ===== rtl/core/mrth_ram.sv =====
module mrth_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 48,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== rtl/core/mrth_datapath.sv =====
module mrth_datapath #(
    parameter int MAX_TRIANGLES = mrth_pkg::DEFAULT_MAX_TRIANGLES,
    localparam int DEPTH = 3 * MAX_TRIANGLES,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  mrth_pkg::dp_cmd_t                     cmd,
    input  logic [AW-1:0]                         raddr,
    input  logic [mrth_pkg::SLOT_W-1:0]           tri_slot,
    input  logic [mrth_pkg::CORNER_W-1:0]         corner,
    input  logic signed [mrth_pkg::COORD_W-1:0]   pos_x,
    input  logic signed [mrth_pkg::COORD_W-1:0]   pos_y,
    input  logic signed [mrth_pkg::COORD_W-1:0]   pos_z,
    input  logic signed [mrth_pkg::COORD_W-1:0]   step_x,
    input  logic signed [mrth_pkg::COORD_W-1:0]   step_y,
    input  logic signed [mrth_pkg::COORD_W-1:0]   step_z,
    input  logic [mrth_pkg::DET_THR_W-1:0]        det_thr,
    input  logic [mrth_pkg::Q_W-1:0]              t_thr,
    output mrth_pkg::dp_stat_t                    stat,
    output logic                                  hit,
    output logic [mrth_pkg::TRI_OUT_W-1:0]        hit_triangle,
    output logic [mrth_pkg::Q_W-1:0]              hit_t,
    output logic [mrth_pkg::Q_W-1:0]              hit_u,
    output logic [mrth_pkg::Q_W-1:0]              hit_v
);

    localparam int CW = mrth_pkg::COORD_W;
    localparam int DW = mrth_pkg::DIFF_W;
    localparam int OW = mrth_pkg::OP_W;
    localparam int PW = mrth_pkg::PROD_W;
    localparam int XW = mrth_pkg::CROSS_W;
    localparam int AC = mrth_pkg::ACC_W;
    localparam int RW = mrth_pkg::REM_W;
    localparam int QW = mrth_pkg::Q_W;

    logic [7:0]           waddr_wide;
    logic [3*CW-1:0]      rdata;
    logic signed [CW-1:0] rd_c [3];

    logic signed [CW-1:0] org_reg [3];
    logic signed [CW-1:0] dir_reg [3];
    logic signed [CW-1:0] c0_reg [3];
    logic signed [DW-1:0] sv_reg [3];
    logic signed [DW-1:0] e1_reg [3];
    logic signed [DW-1:0] e2_reg [3];
    logic signed [XW-1:0] pv_reg [3];
    logic signed [XW-1:0] qv_reg [3];
    logic signed [AC-1:0] det_reg, nu_reg, nv_reg, nt_reg;

    logic signed [OW-1:0] a_op, b_op;
    logic signed [PW-1:0] prod_next, prod_reg;
    mrth_pkg::mac_cmd_t   pcmd_reg;
    logic signed [AC-1:0] prod_ext, term_sh, term, acc_next, acc_reg;
    logic                 hi_part;

    logic                 det_neg;
    logic signed [AC-1:0] mag_next, nua_next, nva_next, nta_next;
    logic signed [AC-1:0] mag_reg, nua_reg, nva_reg, nta_reg, uv_sum;
    logic                 det_bad_reg;

    logic signed [AC-1:0] div_num;
    logic [RW-1:0]        rem_reg, rem2, mag_ext;
    logic [QW-1:0]        q_reg, q_out;
    logic                 sat_reg;
    logic [QW-1:0]        t_res_reg, u_res_reg, v_res_reg;

    assign waddr_wide = {3'b000, tri_slot, 1'b0} + {4'b0000, tri_slot} + {6'b000000, corner};

    mrth_ram #(
        .WIDTH(3 * CW),
        .DEPTH(DEPTH)
    ) u_store (
        .clk  (clk),
        .we   (cmd.ram_we),
        .waddr(AW'(waddr_wide)),
        .wdata({pos_z, pos_y, pos_x}),
        .re   (cmd.ram_re),
        .raddr(raddr),
        .rdata(rdata)
    );

    assign rd_c[0] = rdata[CW-1:0];
    assign rd_c[1] = rdata[2*CW-1:CW];
    assign rd_c[2] = rdata[3*CW-1:2*CW];

    always_ff @(posedge clk)
    begin
        if (cmd.load_query)
        begin
            org_reg[0] <= pos_x;
            org_reg[1] <= pos_y;
            org_reg[2] <= pos_z;
            dir_reg[0] <= step_x;
            dir_reg[1] <= step_y;
            dir_reg[2] <= step_z;
        end
        for (int k = 0; k < 3; k++)
        begin
            if (cmd.ld_c0)
            begin
                c0_reg[k] <= rd_c[k];
                sv_reg[k] <= {org_reg[k][CW-1], org_reg[k]} - {rd_c[k][CW-1], rd_c[k]};
            end
            if (cmd.ld_c1)
            begin
                e1_reg[k] <= {rd_c[k][CW-1], rd_c[k]} - {c0_reg[k][CW-1], c0_reg[k]};
            end
            if (cmd.ld_c2)
            begin
                e2_reg[k] <= {rd_c[k][CW-1], rd_c[k]} - {c0_reg[k][CW-1], c0_reg[k]};
            end
        end
    end

    always_comb
    begin
        unique case (cmd.mac.a_src)
            mrth_pkg::A_DIR:   a_op = {{(OW-CW){dir_reg[cmd.mac.a_idx][CW-1]}},
                                       dir_reg[cmd.mac.a_idx]};
            mrth_pkg::A_SV:    a_op = {sv_reg[cmd.mac.a_idx][DW-1], sv_reg[cmd.mac.a_idx]};
            mrth_pkg::A_PV_LO: a_op = {1'b0, pv_reg[cmd.mac.a_idx][DW-1:0]};
            mrth_pkg::A_PV_HI: a_op = pv_reg[cmd.mac.a_idx][XW-1:DW];
            mrth_pkg::A_QV_LO: a_op = {1'b0, qv_reg[cmd.mac.a_idx][DW-1:0]};
            mrth_pkg::A_QV_HI: a_op = qv_reg[cmd.mac.a_idx][XW-1:DW];
            default:           a_op = '0;
        endcase
        unique case (cmd.mac.b_src)
            mrth_pkg::B_E1:  b_op = {e1_reg[cmd.mac.b_idx][DW-1], e1_reg[cmd.mac.b_idx]};
            mrth_pkg::B_E2:  b_op = {e2_reg[cmd.mac.b_idx][DW-1], e2_reg[cmd.mac.b_idx]};
            mrth_pkg::B_SV:  b_op = {sv_reg[cmd.mac.b_idx][DW-1], sv_reg[cmd.mac.b_idx]};
            mrth_pkg::B_DIR: b_op = {{(OW-CW){dir_reg[cmd.mac.b_idx][CW-1]}},
                                     dir_reg[cmd.mac.b_idx]};
            default:         b_op = '0;
        endcase
    end

    assign prod_next = a_op * b_op;
    assign prod_ext  = {{(AC-PW){prod_reg[PW-1]}}, prod_reg};
    assign hi_part   = (pcmd_reg.a_src == mrth_pkg::A_PV_HI) ||
                       (pcmd_reg.a_src == mrth_pkg::A_QV_HI);
    assign term_sh   = hi_part ? (prod_ext <<< mrth_pkg::HI_SHIFT) : prod_ext;
    assign term      = pcmd_reg.neg ? -term_sh : term_sh;
    assign acc_next  = pcmd_reg.first ? term : acc_reg + term;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pcmd_reg <= '0;
        end
        else
        begin
            pcmd_reg <= cmd.mac;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        if (pcmd_reg.en)
        begin
            acc_reg <= acc_next;
            if (pcmd_reg.last)
            begin
                unique case (pcmd_reg.dest)
                    mrth_pkg::D_PV0: pv_reg[0] <= acc_next[XW-1:0];
                    mrth_pkg::D_PV1: pv_reg[1] <= acc_next[XW-1:0];
                    mrth_pkg::D_PV2: pv_reg[2] <= acc_next[XW-1:0];
                    mrth_pkg::D_QV0: qv_reg[0] <= acc_next[XW-1:0];
                    mrth_pkg::D_QV1: qv_reg[1] <= acc_next[XW-1:0];
                    mrth_pkg::D_QV2: qv_reg[2] <= acc_next[XW-1:0];
                    mrth_pkg::D_DET: det_reg <= acc_next;
                    mrth_pkg::D_NU:  nu_reg <= acc_next;
                    mrth_pkg::D_NV:  nv_reg <= acc_next;
                    mrth_pkg::D_NT:  nt_reg <= acc_next;
                    default: ;
                endcase
            end
        end
    end

    // The sign of the determinant is folded into the numerators.
    assign det_neg  = det_reg[AC-1];
    assign mag_next = det_neg ? -det_reg : det_reg;
    assign nua_next = det_neg ? -nu_reg : nu_reg;
    assign nva_next = det_neg ? -nv_reg : nv_reg;
    assign nta_next = det_neg ? -nt_reg : nt_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.chk)
        begin
            mag_reg     <= mag_next;
            nua_reg     <= nua_next;
            nva_reg     <= nva_next;
            nta_reg     <= nta_next;
            det_bad_reg <= (det_reg == '0) ||
                           ($unsigned(mag_next) < {{(AC-mrth_pkg::DET_THR_W){1'b0}}, det_thr});
        end
    end

    assign uv_sum = nua_reg + nva_reg;

    assign stat.det_bad   = det_bad_reg;
    assign stat.range_bad = nua_reg[AC-1] || (mag_reg < nua_reg) ||
                            nva_reg[AC-1] || (mag_reg < uv_sum) ||
                            nta_reg[AC-1] || (mag_reg < nta_reg);

    always_comb
    begin
        unique case (cmd.div_sel)
            mrth_pkg::SEL_T: div_num = nta_reg;
            mrth_pkg::SEL_U: div_num = nua_reg;
            mrth_pkg::SEL_V: div_num = nva_reg;
            default:         div_num = '0;
        endcase
    end

    assign mag_ext = {1'b0, mag_reg};
    assign rem2    = {rem_reg[RW-2:0], 1'b0};
    assign q_out   = sat_reg ? mrth_pkg::Q_ONE : q_reg;
    assign stat.t_low = q_out < t_thr;

    always_ff @(posedge clk)
    begin
        if (cmd.div_init)
        begin
            rem_reg <= {1'b0, div_num};
            q_reg   <= '0;
            sat_reg <= $unsigned(div_num) >= $unsigned(mag_reg);
        end
        else if (cmd.div_step)
        begin
            if (rem2 >= mag_ext)
            begin
                rem_reg <= rem2 - mag_ext;
                q_reg   <= {q_reg[QW-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem2;
                q_reg   <= {q_reg[QW-2:0], 1'b0};
            end
        end
        if (cmd.div_save)
        begin
            unique case (cmd.div_sel)
                mrth_pkg::SEL_T: t_res_reg <= q_out;
                mrth_pkg::SEL_U: u_res_reg <= q_out;
                mrth_pkg::SEL_V: v_res_reg <= q_out;
                default: ;
            endcase
        end
        if (cmd.out_load)
        begin
            hit          <= cmd.out_hit;
            hit_triangle <= cmd.out_hit ? cmd.out_tri : '0;
            hit_t        <= cmd.out_hit ? t_res_reg : '0;
            hit_u        <= cmd.out_hit ? u_res_reg : '0;
            hit_v        <= cmd.out_hit ? v_res_reg : '0;
        end
    end

endmodule

// ===== rtl/core/mrth_ctrl.sv =====
module mrth_ctrl #(
    parameter int MAX_TRIANGLES = mrth_pkg::DEFAULT_MAX_TRIANGLES,
    localparam int DEPTH = 3 * MAX_TRIANGLES,
    localparam int AW = $clog2(DEPTH),
    localparam int CW = $clog2(MAX_TRIANGLES + 1)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          kind,
    input  logic [mrth_pkg::SLOT_W-1:0]   tri_slot,
    input  logic [mrth_pkg::CORNER_W-1:0] corner,
    output logic                          out_valid,
    input  logic                          out_ready,
    input  logic [mrth_pkg::TC_W-1:0]     tri_count,
    input  mrth_pkg::dp_stat_t            stat,
    output mrth_pkg::dp_cmd_t             cmd,
    output logic [AW-1:0]                 raddr
);

    localparam int SW = mrth_pkg::STEP_W;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_LOAD   = 4'd1;
    localparam logic [3:0] S_MAC    = 4'd2;
    localparam logic [3:0] S_CHK1   = 4'd3;
    localparam logic [3:0] S_CHK2   = 4'd4;
    localparam logic [3:0] S_DIVI   = 4'd5;
    localparam logic [3:0] S_DIVS   = 4'd6;
    localparam logic [3:0] S_DIVD   = 4'd7;
    localparam logic [3:0] S_NEXT   = 4'd8;
    localparam logic [3:0] S_RESULT = 4'd9;

    logic [3:0]    state_reg, state_next;
    logic [SW-1:0] step_reg, step_next;
    logic [CW-1:0] tri_reg, tri_next;
    logic [CW-1:0] count_reg, count_next;
    logic [AW-1:0] base_reg, base_next;
    logic [1:0]    sel_reg, sel_next;
    logic          hitf_reg, hitf_next;
    logic          out_valid_reg, out_valid_next;
    logic [CW-1:0] count_lim;
    logic          slot_ok, corner_ok;

    assign count_lim = ({27'd0, tri_count} > 32'(MAX_TRIANGLES)) ?
                       CW'(MAX_TRIANGLES) : CW'(tri_count);
    assign slot_ok   = {28'd0, tri_slot} < 32'(MAX_TRIANGLES);
    assign corner_ok = corner < mrth_pkg::NUM_CORNERS;
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        tri_next       = tri_reg;
        count_next     = count_reg;
        base_next      = base_reg;
        sel_next       = sel_reg;
        hitf_next      = hitf_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        raddr          = base_reg + AW'(step_reg[1:0]);
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (kind == mrth_pkg::KIND_CORNER)
                    begin
                        cmd.ram_we = slot_ok && corner_ok;
                    end
                    else
                    begin
                        cmd.load_query = 1'b1;
                        count_next     = count_lim;
                        tri_next       = '0;
                        base_next      = '0;
                        hitf_next      = 1'b0;
                        step_next      = '0;
                        state_next     = (count_lim == '0) ? S_RESULT : S_LOAD;
                    end
                end
            end
            S_LOAD:
            begin
                cmd.ram_re = (step_reg != SW'(mrth_pkg::LOAD_LAST));
                cmd.ld_c0  = (step_reg == SW'(1));
                cmd.ld_c1  = (step_reg == SW'(2));
                cmd.ld_c2  = (step_reg == SW'(mrth_pkg::LOAD_LAST));
                if (step_reg == SW'(mrth_pkg::LOAD_LAST))
                begin
                    step_next  = '0;
                    state_next = S_MAC;
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            S_MAC:
            begin
                cmd.mac = mrth_pkg::mac_step(step_reg);
                if (step_reg == SW'(mrth_pkg::MAC_STEPS))
                begin
                    state_next = S_CHK1;
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            S_CHK1:
            begin
                cmd.chk    = 1'b1;
                state_next = S_CHK2;
            end
            S_CHK2:
            begin
                if (stat.det_bad || stat.range_bad)
                begin
                    state_next = S_NEXT;
                end
                else
                begin
                    sel_next   = mrth_pkg::SEL_T;
                    state_next = S_DIVI;
                end
            end
            S_DIVI:
            begin
                cmd.div_init = 1'b1;
                cmd.div_sel  = sel_reg;
                step_next    = '0;
                state_next   = S_DIVS;
            end
            S_DIVS:
            begin
                cmd.div_step = 1'b1;
                if (step_reg == SW'(mrth_pkg::DIV_STEPS - 1))
                begin
                    state_next = S_DIVD;
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            S_DIVD:
            begin
                cmd.div_sel = sel_reg;
                if ((sel_reg == mrth_pkg::SEL_T) && stat.t_low)
                begin
                    state_next = S_NEXT;
                end
                else
                begin
                    cmd.div_save = 1'b1;
                    if (sel_reg == mrth_pkg::SEL_V)
                    begin
                        hitf_next  = 1'b1;
                        state_next = S_RESULT;
                    end
                    else
                    begin
                        sel_next   = (sel_reg == mrth_pkg::SEL_T) ?
                                     mrth_pkg::SEL_U : mrth_pkg::SEL_V;
                        state_next = S_DIVI;
                    end
                end
            end
            S_NEXT:
            begin
                if (CW'(tri_reg + 1'b1) == count_reg)
                begin
                    hitf_next  = 1'b0;
                    state_next = S_RESULT;
                end
                else
                begin
                    tri_next   = tri_reg + 1'b1;
                    base_next  = base_reg + AW'(3);
                    step_next  = '0;
                    state_next = S_LOAD;
                end
            end
            S_RESULT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load   = 1'b1;
                    cmd.out_hit    = hitf_reg;
                    cmd.out_tri    = mrth_pkg::TRI_OUT_W'(tri_reg);
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_reg      <= '0;
            tri_reg       <= '0;
            count_reg     <= '0;
            base_reg      <= '0;
            sel_reg       <= mrth_pkg::SEL_T;
            hitf_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            tri_reg       <= tri_next;
            count_reg     <= count_next;
            base_reg      <= base_next;
            sel_reg       <= sel_next;
            hitf_reg      <= hitf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MAC) |-> (step_reg <= SW'(mrth_pkg::MAC_STEPS)))
        else $error("Product sequencer ran past its last step.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LOAD) |-> (tri_reg < count_reg))
        else $error("Triangle walk went beyond the triangle count.");

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || out_ready))
        else $error("Result register overwritten before its transfer.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RESULT && out_valid_reg && !out_ready) |=>
        (state_reg == S_RESULT && out_valid_reg))
        else $error("Pending result lost while the output was stalled.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && kind == mrth_pkg::KIND_QUERY && count_lim != '0) |=>
        (state_reg == S_LOAD && tri_reg == '0))
        else $error("Query did not start at the first triangle.");

endmodule

// ===== tb/tb_mesh_ray_triangle_hit.sv =====
`timescale 1ns / 1ps

module tb_mesh_ray_triangle_hit;
    import mrth_pkg::*;

    localparam int ONE = 65536;
    localparam int WATCH_LIMIT = 20000;
    localparam int HOLD_CYCLES = 600;
    localparam int STORE_N = 3 * DEFAULT_MAX_TRIANGLES;

    typedef logic signed [127:0] wide_t;

    typedef struct packed {
        logic                       kind;
        logic [SLOT_W-1:0]          slot;
        logic [CORNER_W-1:0]        crn;
        logic signed [COORD_W-1:0]  px;
        logic signed [COORD_W-1:0]  py;
        logic signed [COORD_W-1:0]  pz;
        logic signed [COORD_W-1:0]  sx;
        logic signed [COORD_W-1:0]  sy;
        logic signed [COORD_W-1:0]  sz;
    } ray_item_t;

    typedef struct packed {
        logic                 hit;
        logic [TRI_OUT_W-1:0] tri_idx;
        logic [Q_W-1:0]       t;
        logic [Q_W-1:0]       u;
        logic [Q_W-1:0]       v;
    } hit_rec_t;

    typedef struct packed {
        ray_item_t item;
        logic      typed;
        hit_rec_t  want;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic kind = 1'b0;
    logic [SLOT_W-1:0] tri_slot = '0;
    logic [CORNER_W-1:0] corner = '0;
    logic signed [COORD_W-1:0] pos_x = '0, pos_y = '0, pos_z = '0;
    logic signed [COORD_W-1:0] step_x = '0, step_y = '0, step_z = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic hit;
    logic [TRI_OUT_W-1:0] hit_triangle;
    logic [Q_W-1:0] hit_t, hit_u, hit_v;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    logic signed [COORD_W-1:0] store_x [STORE_N];
    logic signed [COORD_W-1:0] store_y [STORE_N];
    logic signed [COORD_W-1:0] store_z [STORE_N];
    logic [TC_W-1:0] tri_count_q = TC_RESET;
    logic [DET_THR_W-1:0] det_thr_q = DET_THR_RESET;
    logic [Q_W-1:0] t_thr_q = T_THR_RESET;

    hit_rec_t pending_hits [$];
    int errors = 0;
    int idle_cycles = 0;
    bit calm = 1'b0;
    bit hold_req = 1'b0;

    mesh_ray_triangle_hit dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .kind(kind), .tri_slot(tri_slot), .corner(corner),
        .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
        .step_x(step_x), .step_y(step_y), .step_z(step_z),
        .out_valid(out_valid), .out_ready(out_ready),
        .hit(hit), .hit_triangle(hit_triangle),
        .hit_t(hit_t), .hit_u(hit_u), .hit_v(hit_v),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #4 clk = ~clk;

    function automatic logic [Q_W-1:0] frac_q30(input wide_t n, input wide_t m);
        logic [191:0] num;
        logic [191:0] q;
        if (n >= m) return Q_ONE;
        num = {64'd0, n} << FRAC_BITS;
        q = num / {64'd0, m};
        return q[Q_W-1:0];
    endfunction

    function automatic hit_rec_t trace_ray(input ray_item_t it);
        hit_rec_t r;
        wide_t o[3], d[3], c0[3], e1[3], e2[3], sv[3], pv[3], qv[3];
        wide_t det, mag, nu, nv, nt;
        logic [Q_W-1:0] tq;
        int walk;
        r = '0;
        o[0] = it.px; o[1] = it.py; o[2] = it.pz;
        d[0] = it.sx; d[1] = it.sy; d[2] = it.sz;
        walk = (tri_count_q > DEFAULT_MAX_TRIANGLES) ? DEFAULT_MAX_TRIANGLES : tri_count_q;
        for (int k = 0; k < walk; k++) begin
            c0[0] = store_x[3*k]; c0[1] = store_y[3*k]; c0[2] = store_z[3*k];
            e1[0] = wide_t'(store_x[3*k+1]) - c0[0];
            e1[1] = wide_t'(store_y[3*k+1]) - c0[1];
            e1[2] = wide_t'(store_z[3*k+1]) - c0[2];
            e2[0] = wide_t'(store_x[3*k+2]) - c0[0];
            e2[1] = wide_t'(store_y[3*k+2]) - c0[1];
            e2[2] = wide_t'(store_z[3*k+2]) - c0[2];
            for (int j = 0; j < 3; j++) sv[j] = o[j] - c0[j];
            pv[0] = d[1] * e2[2] - d[2] * e2[1];
            pv[1] = d[2] * e2[0] - d[0] * e2[2];
            pv[2] = d[0] * e2[1] - d[1] * e2[0];
            det = e1[0] * pv[0] + e1[1] * pv[1] + e1[2] * pv[2];
            if (det == 0) continue;
            mag = (det < 0) ? -det : det;
            if (mag < wide_t'({88'd0, det_thr_q})) continue;
            qv[0] = sv[1] * e1[2] - sv[2] * e1[1];
            qv[1] = sv[2] * e1[0] - sv[0] * e1[2];
            qv[2] = sv[0] * e1[1] - sv[1] * e1[0];
            nu = sv[0] * pv[0] + sv[1] * pv[1] + sv[2] * pv[2];
            nv = d[0] * qv[0] + d[1] * qv[1] + d[2] * qv[2];
            nt = e2[0] * qv[0] + e2[1] * qv[1] + e2[2] * qv[2];
            if (det < 0) begin
                nu = -nu; nv = -nv; nt = -nt;
            end
            if (nu < 0 || nu > mag) continue;
            if (nv < 0 || nu + nv > mag) continue;
            if (nt < 0 || nt > mag) continue;
            tq = frac_q30(nt, mag);
            if (tq < t_thr_q) continue;
            r.hit = 1'b1;
            r.tri_idx = k[TRI_OUT_W-1:0];
            r.t = tq;
            r.u = frac_q30(nu, mag);
            r.v = frac_q30(nv, mag);
            return r;
        end
        return r;
    endfunction

    task automatic send_item(input ray_item_t it, input logic typed, input hit_rec_t want);
        int idx;
        if (!calm && $urandom_range(99) < 9) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge clk);
        end
        kind <= it.kind; tri_slot <= it.slot; corner <= it.crn;
        pos_x <= it.px; pos_y <= it.py; pos_z <= it.pz;
        step_x <= it.sx; step_y <= it.sy; step_z <= it.sz;
        in_valid <= 1'b1;
        do @(posedge clk); while (!in_ready);
        if (it.kind == KIND_QUERY) begin
            pending_hits.push_back(typed ? want : trace_ray(it));
        end else if (it.crn < NUM_CORNERS) begin
            idx = 3 * it.slot + it.crn;
            store_x[idx] = it.px; store_y[idx] = it.py; store_z[idx] = it.pz;
        end
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (pending_hits.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_index <= idx;
        cfg_data <= val;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            REG_TRI_COUNT: tri_count_q = val[TC_W-1:0];
            REG_DET_THR:   det_thr_q = val[DET_THR_W-1:0];
            REG_T_THR:     t_thr_q = val[Q_W-1:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic ray_item_t corner_item(input int slot, input int c,
                                              input int x, input int y, input int z);
        ray_item_t it;
        it = '0;
        it.kind = KIND_CORNER;
        it.slot = slot[SLOT_W-1:0];
        it.crn = c[CORNER_W-1:0];
        it.px = x; it.py = y; it.pz = z;
        return it;
    endfunction

    function automatic ray_item_t query_item(input int ox, input int oy, input int oz,
                                             input int dx, input int dy, input int dz);
        ray_item_t it;
        it = '0;
        it.kind = KIND_QUERY;
        it.px = ox; it.py = oy; it.pz = oz;
        it.sx = dx; it.sy = dy; it.sz = dz;
        return it;
    endfunction

    function automatic int small_coord();
        return $urandom_range(8 * ONE) - 4 * ONE;
    endfunction

    function automatic ray_item_t noise_item();
        ray_item_t it;
        logic [223:0] raw;
        raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        it = raw[$bits(ray_item_t)-1:0];
        return it;
    endfunction

    task automatic new_triangle(input int slot);
        int bx, by, bz;
        bx = small_coord(); by = small_coord(); bz = small_coord();
        send_item(corner_item(slot, 0, bx, by, bz), 1'b0, '0);
        send_item(corner_item(slot, 1, bx + small_coord() / 2, by + small_coord() / 2,
                              bz + small_coord() / 2), 1'b0, '0);
        send_item(corner_item(slot, 2, bx + small_coord() / 2, by + small_coord() / 2,
                              bz + small_coord() / 2), 1'b0, '0);
    endtask

    function automatic ray_item_t aimed_query(input int k);
        longint a, b, m, tgt[3], org[3], c0[3], c1[3], c2[3];
        ray_item_t it;
        c0[0] = store_x[3*k]; c0[1] = store_y[3*k]; c0[2] = store_z[3*k];
        c1[0] = store_x[3*k+1]; c1[1] = store_y[3*k+1]; c1[2] = store_z[3*k+1];
        c2[0] = store_x[3*k+2]; c2[1] = store_y[3*k+2]; c2[2] = store_z[3*k+2];
        a = $urandom_range(300);
        b = $urandom_range(300);
        m = $urandom_range(100, 400);
        for (int j = 0; j < 3; j++) begin
            tgt[j] = c0[j] + (a * (c1[j] - c0[j]) + b * (c2[j] - c0[j])) / 256;
            org[j] = small_coord() * 2;
        end
        it = query_item(int'(org[0]), int'(org[1]), int'(org[2]),
                        int'((tgt[0] - org[0]) * m / 128), int'((tgt[1] - org[1]) * m / 128),
                        int'((tgt[2] - org[2]) * m / 128));
        return it;
    endfunction

    stim_row_t reset_rows [] = '{
        '{query_item(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                     32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000), 1'b1, '0},
        '{query_item(32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff,
                     32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff), 1'b1, '0},
        '{corner_item(0, 0, 0, 0, 0), 1'b0, '0},
        '{corner_item(0, 1, ONE, 0, 0), 1'b0, '0},
        '{corner_item(0, 2, 0, ONE, 0), 1'b0, '0},
        '{corner_item(0, 3, -1, -1, -1), 1'b0, '0},
        '{corner_item(1, 0, 100 * ONE, 0, 0), 1'b0, '0},
        '{corner_item(1, 1, 101 * ONE, 0, 0), 1'b0, '0},
        '{corner_item(1, 2, 100 * ONE, ONE, 0), 1'b0, '0}
    };

    stim_row_t geom_rows [] = '{
        '{query_item(ONE / 4, ONE / 4, ONE, 0, 0, -2 * ONE), 1'b1,
          '{1'b1, 4'd0, 31'h2000_0000, 31'h1000_0000, 31'h1000_0000}},
        '{query_item(ONE / 4, ONE / 4, ONE, ONE, 0, 0), 1'b1, '0},
        '{query_item(ONE / 4, ONE / 4, -ONE, 0, 0, -2 * ONE), 1'b0, '0},
        '{query_item(ONE / 4, ONE / 4, ONE, 0, 0, -ONE / 2), 1'b0, '0},
        '{query_item(ONE / 4, ONE / 4, ONE, 0, 0, -ONE), 1'b0, '0},
        '{query_item(0, ONE / 2, ONE, 0, 0, -ONE), 1'b0, '0},
        '{query_item(ONE / 2, ONE / 2, ONE, 0, 0, -ONE), 1'b0, '0},
        '{query_item(0, 0, ONE, 0, 0, -ONE), 1'b0, '0},
        '{query_item(100 * ONE + ONE / 4, ONE / 4, ONE, 0, 0, -ONE), 1'b0, '0},
        '{query_item(ONE / 4, ONE / 4, 0, 0, 0, -ONE), 1'b0, '0},
        '{query_item(ONE / 4, ONE / 4, ONE, 0, 0, 0), 1'b0, '0}
    };

    always @(posedge clk) begin
        if (out_valid && out_ready) begin
            if (pending_hits.size() == 0) begin
                $display("%0t: result with none expected: hit=%0d tri=%0d t=%h u=%h v=%h",
                         $time, hit, hit_triangle, hit_t, hit_u, hit_v);
                errors++;
            end else begin
                hit_rec_t w;
                w = pending_hits.pop_front();
                if (hit !== w.hit) begin
                    $display("%0t: hit expected %0d actual %0d", $time, w.hit, hit);
                    errors++;
                end
                if (hit_triangle !== w.tri_idx) begin
                    $display("%0t: hit_triangle expected %0d actual %0d",
                             $time, w.tri_idx, hit_triangle);
                    errors++;
                end
                if (hit_t !== w.t) begin
                    $display("%0t: hit_t expected %h actual %h", $time, w.t, hit_t);
                    errors++;
                end
                if (hit_u !== w.u) begin
                    $display("%0t: hit_u expected %h actual %h", $time, w.u, hit_u);
                    errors++;
                end
                if (hit_v !== w.v) begin
                    $display("%0t: hit_v expected %h actual %h", $time, w.v, hit_v);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCH_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            if (hold_req) begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req = 1'b0;
            end else begin
                out_ready <= calm || ($urandom_range(99) >= 9);
            end
        end
    end

    initial begin
        int eff, pick, seg_len;
        for (int i = 0; i < STORE_N; i++) begin
            store_x[i] = '0; store_y[i] = '0; store_z[i] = '0;
        end
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (reset_rows[i]) send_item(reset_rows[i].item, reset_rows[i].typed,
                                          reset_rows[i].want);
        drain();
        write_reg(REG_TRI_COUNT, 2);
        foreach (geom_rows[i]) send_item(geom_rows[i].item, geom_rows[i].typed,
                                         geom_rows[i].want);
        drain();
        write_reg(REG_DET_THR, '0);
        write_reg(REG_T_THR, '0);
        send_item(geom_rows[2].item, 1'b0, '0);
        send_item(geom_rows[9].item, 1'b0, '0);
        send_item(geom_rows[10].item, 1'b0, '0);
        drain();
        write_reg(REG_T_THR, Q_ONE);
        send_item(geom_rows[4].item, 1'b0, '0);
        send_item(geom_rows[0].item, 1'b0, '0);
        drain();
        write_reg(REG_DET_THR, {CFG_DATA_W{1'b1}});
        write_reg(2'd3, {CFG_DATA_W{1'b1}});
        send_item(geom_rows[0].item, 1'b0, '0);
        drain();

        for (int s = 0; s < DEFAULT_MAX_TRIANGLES; s++) new_triangle(s);
        drain();

        for (int seg = 0; seg < 18; seg++) begin
            case (seg)
                0: begin
                    write_reg(REG_TRI_COUNT, 31);
                    write_reg(REG_DET_THR, DET_THR_RESET);
                    write_reg(REG_T_THR, T_THR_RESET);
                end
                1: write_reg(REG_TRI_COUNT, DEFAULT_MAX_TRIANGLES);
                2: write_reg(REG_TRI_COUNT, 0);
                default: begin
                    write_reg(REG_TRI_COUNT, $urandom_range(1, 4));
                    case ($urandom_range(3))
                        0: write_reg(REG_DET_THR, '0);
                        1: write_reg(REG_DET_THR, CFG_DATA_W'({$urandom, $urandom}));
                        2: write_reg(REG_DET_THR, $urandom_range(1 << 20));
                        default: write_reg(REG_DET_THR, DET_THR_RESET);
                    endcase
                    case ($urandom_range(3))
                        0: write_reg(REG_T_THR, '0);
                        1: write_reg(REG_T_THR, $urandom);
                        2: write_reg(REG_T_THR, $urandom_range(Q_ONE));
                        default: write_reg(REG_T_THR, T_THR_RESET);
                    endcase
                end
            endcase
            eff = (tri_count_q > DEFAULT_MAX_TRIANGLES) ? DEFAULT_MAX_TRIANGLES : tri_count_q;
            seg_len = (seg < 2) ? 30 : 75;
            calm = (seg == 8);
            for (int n = 0; n < seg_len; n++) begin
                if (seg == 5 && n == 20) hold_req = 1'b1;
                pick = $urandom_range(99);
                if (pick < 65)
                    send_item(aimed_query($urandom_range(eff > 0 ? eff - 1 : 15)), 1'b0, '0);
                else if (pick < 75)
                    new_triangle($urandom_range(15));
                else if (pick < 85) begin
                    ray_item_t it;
                    it = noise_item();
                    it.kind = KIND_QUERY;
                    send_item(it, 1'b0, '0);
                end else if (pick < 92) begin
                    ray_item_t it;
                    it = noise_item();
                    it.kind = KIND_CORNER;
                    send_item(it, 1'b0, '0);
                end else begin
                    ray_item_t it;
                    it = noise_item();
                    it.kind = KIND_CORNER;
                    it.crn = 2'd3;
                    send_item(it, 1'b0, '0);
                end
            end
            calm = 1'b0;
            drain();
        end

        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ===== mesh_ray_triangle_hit.f =====
rtl/core/mrth_pkg.sv
rtl/core/mrth_ram.sv
rtl/core/mrth_datapath.sv
rtl/core/mrth_ctrl.sv
rtl/core/mesh_ray_triangle_hit.sv
tb/tb_mesh_ray_triangle_hit.sv
